### rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types and constants shared by the inertial sample conditioner files.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned NumAxes  = 6;
  localparam int unsigned RawW     = 16;
  localparam int unsigned AxisW    = 24;
  localparam int unsigned KeepW    = 16;
  localparam int unsigned GravW    = 15;
  localparam int unsigned DutyW    = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // 21.0 degrees in Q8.8, and 256 / 333.87 in Q0.16
  localparam logic signed [15:0] TempBaseQ8  = 16'sd5376;
  localparam logic signed [16:0] TempScaleQ16 = 17'sd50251;
  localparam logic [DutyW-1:0]   DutyOn      = 15'd20000;
  localparam logic [DutyW-1:0]   DutyOff     = 15'd0;

  localparam logic [GravW-1:0]      GravReset = 15'd4096;
  localparam logic [KeepW-1:0]      KeepReset = 16'd6554;
  localparam logic signed [15:0]    ThrReset  = 16'sd11520;

  typedef enum logic [CfgIdxW-1:0] {
    RegGyroOffX  = 3'd0,
    RegGyroOffY  = 3'd1,
    RegGyroOffZ  = 3'd2,
    RegGravLimit = 3'd3,
    RegKeep      = 3'd4,
    RegHeaterThr = 3'd5
  } reg_idx_e;

  typedef logic signed [AxisW-1:0] axis_t;

  typedef struct packed {
    logic signed [RawW-1:0] accel_x_raw;
    logic signed [RawW-1:0] accel_y_raw;
    logic signed [RawW-1:0] accel_z_raw;
    logic signed [RawW-1:0] temp_raw;
    logic signed [RawW-1:0] gyro_x_raw;
    logic signed [RawW-1:0] gyro_y_raw;
    logic signed [RawW-1:0] gyro_z_raw;
  } frame_t;

  typedef struct packed {
    axis_t                  accel_x_filt;
    axis_t                  accel_y_filt;
    axis_t                  accel_z_filt;
    axis_t                  gyro_x_filt;
    axis_t                  gyro_y_filt;
    axis_t                  gyro_z_filt;
    logic signed [15:0]     temperature;
    logic [DutyW-1:0]       heater_duty;
  } result_t;

  // settings used by the conditioning stage
  typedef struct packed {
    logic signed [RawW-1:0] gyro_off_x;
    logic signed [RawW-1:0] gyro_off_y;
    logic signed [RawW-1:0] gyro_off_z;
    logic [GravW-1:0]       grav_limit;
  } cond_cfg_t;

  // conditioned frame: axes in output order, accel x..z then gyro x..z
  typedef struct packed {
    axis_t [NumAxes-1:0]    ax;
    logic signed [15:0]     temp_q8;
  } cond_t;

endpackage

### rtl/isc_if.sv
// ----------------------------------------------------------------------------
// isc_if
// Valid/ready channels of the inertial sample conditioner.
// ----------------------------------------------------------------------------
interface isc_frame_if import isc_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isc_result_if import isc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isc_cfg_if import isc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/isc_front.sv
// ----------------------------------------------------------------------------
// isc_front
// Input stage: clamps accel, removes gyro offsets, converts temperature.
// ----------------------------------------------------------------------------
module isc_front import isc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  frame_t    frame_i,
  input  cond_cfg_t cfg_i,
  input  logic      adv_i,
  output logic      valid_o,
  output cond_t     cond_o
);

  logic              valid_q;
  cond_t             cond_q;
  cond_t             cond_d;
  logic              accept;

  function automatic axis_t clamp_accel(logic signed [RawW-1:0] a,
                                        logic [GravW-1:0] g);
    logic signed [RawW:0] a_w;
    logic signed [RawW:0] g_w;
    logic signed [RawW:0] r;
    a_w = {a[RawW-1], a};
    g_w = {2'b00, g};
    r   = a_w;
    if (a_w > g_w) r = g_w;
    if (a_w < -g_w) r = -g_w;
    return {r[RawW-1:0], 8'h00};
  endfunction

  function automatic axis_t sub_offset(logic signed [RawW-1:0] raw,
                                       logic signed [RawW-1:0] off);
    logic [RawW-1:0] d;
    d = raw - off;  // wraps to 16 bits
    return {d, 8'h00};
  endfunction

  logic signed [32:0] temp_prod;
  logic signed [33:0] temp_rnd;

  always_comb begin
    temp_prod = frame_i.temp_raw * TempScaleQ16;
    temp_rnd  = {temp_prod[32], temp_prod} + 34'sd32768;
    cond_d.ax[0]   = clamp_accel(frame_i.accel_x_raw, cfg_i.grav_limit);
    cond_d.ax[1]   = clamp_accel(frame_i.accel_y_raw, cfg_i.grav_limit);
    cond_d.ax[2]   = clamp_accel(frame_i.accel_z_raw, cfg_i.grav_limit);
    cond_d.ax[3]   = sub_offset(frame_i.gyro_x_raw, cfg_i.gyro_off_x);
    cond_d.ax[4]   = sub_offset(frame_i.gyro_y_raw, cfg_i.gyro_off_y);
    cond_d.ax[5]   = sub_offset(frame_i.gyro_z_raw, cfg_i.gyro_off_z);
    cond_d.temp_q8 = TempBaseQ8 + temp_rnd[31:16];
  end

  assign in_ready_o = !valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cond_q <= cond_d;
    end
  end

  assign valid_o = valid_q;
  assign cond_o  = cond_q;

endmodule

### rtl/isc_lane.sv
// ----------------------------------------------------------------------------
// isc_lane
// One axis of the first-order low-pass filter with its own history register.
// ----------------------------------------------------------------------------
module isc_lane import isc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             first_i,
  input  logic [KeepW-1:0] keep_i,
  input  axis_t            x_i,
  output axis_t            y_o
);

  axis_t              prev_q;
  axis_t              y_d;
  logic signed [AxisW:0]       diff;
  logic signed [AxisW+KeepW+1:0] prod;
  logic signed [AxisW+KeepW+1:0] rnd;

  // y = x + round(K * (prev - x) / 2^16), same as the weighted sum form
  always_comb begin
    diff = {prev_q[AxisW-1], prev_q} - {x_i[AxisW-1], x_i};
    prod = $signed({1'b0, keep_i}) * diff;
    rnd  = prod + (AxisW+KeepW+2)'(32768);
    if (first_i) begin
      y_d = x_i;
    end else begin
      y_d = x_i + rnd[KeepW+AxisW-1:KeepW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (fire_i) begin
      prev_q <= y_d;
    end
  end

  assign y_o = y_d;

endmodule

### rtl/isc_merge.sv
// ----------------------------------------------------------------------------
// isc_merge
// Gathers the lane outputs and temperature into a result and queues it in a
// two-entry skid buffer toward the output channel.
// ----------------------------------------------------------------------------
module isc_merge import isc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  output logic                room_o,
  input  axis_t [NumAxes-1:0] y_i,
  input  logic signed [15:0]  temp_i,
  input  logic signed [15:0]  thr_i,
  output logic                valid_o,
  input  logic                ready_i,
  output result_t             data_o
);

  result_t    buf_q [2];
  result_t    res_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  always_comb begin
    res_d.accel_x_filt = y_i[0];
    res_d.accel_y_filt = y_i[1];
    res_d.accel_z_filt = y_i[2];
    res_d.gyro_x_filt  = y_i[3];
    res_d.gyro_y_filt  = y_i[4];
    res_d.gyro_z_filt  = y_i[5];
    res_d.temperature  = temp_i;
    res_d.heater_duty  = (temp_i > thr_i) ? DutyOff : DutyOn;
  end

  assign pop     = valid_o && ready_i;
  assign room_o  = (count_q != 2'd2) || ready_i;
  assign valid_o = (count_q != 2'd0);
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (wr_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !wr_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

endmodule

### rtl/imu_sample_conditioner_unit.sv
// ----------------------------------------------------------------------------
// imu_sample_conditioner_unit
// Per-frame accel clamp, gyro offset removal, six-lane low-pass filter and
// temperature / heater duty conversion.
// ----------------------------------------------------------------------------
//  channel   dir  payload                       transaction when
//  frame_i   in   7 x 16-bit raw samples        valid && ready
//  result_o  out  6 x 24-bit axes, temp, duty   valid && ready
//  cfg_i     in   3-bit index, 16-bit data      valid && ready (ready is 1)
//
// One frame per cycle while the output keeps up; a frame is registered in
// the input stage, then in the skid buffer. The filter recurrence per axis
// (subtract, 17x25 multiply, add) closes inside each lane and sets the rate.
// Reset clears the filter history, sets the first-frame flag and loads the
// register defaults. A stalled output fills a two-entry skid buffer, then
// holds the input stage and finally drops frame_i.ready.
// ----------------------------------------------------------------------------
module imu_sample_conditioner_unit import isc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  isc_frame_if.sink    frame_i,
  isc_result_if.source result_o,
  isc_cfg_if.sink      cfg_i
);

  logic signed [RawW-1:0] gyro_off_x_q;
  logic signed [RawW-1:0] gyro_off_y_q;
  logic signed [RawW-1:0] gyro_off_z_q;
  logic [GravW-1:0]       grav_limit_q;
  logic [KeepW-1:0]       keep_q;
  logic signed [15:0]     heater_thr_q;
  logic                   first_q;

  cond_cfg_t           cond_cfg;
  cond_t               cond;
  logic                a_valid;
  logic                room;
  logic                fire;
  axis_t [NumAxes-1:0] y;
  reg_idx_e            cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = reg_idx_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_off_x_q <= '0;
      gyro_off_y_q <= '0;
      gyro_off_z_q <= '0;
      grav_limit_q <= GravReset;
      keep_q       <= KeepReset;
      heater_thr_q <= ThrReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx)
        RegGyroOffX:  gyro_off_x_q <= cfg_i.wdata;
        RegGyroOffY:  gyro_off_y_q <= cfg_i.wdata;
        RegGyroOffZ:  gyro_off_z_q <= cfg_i.wdata;
        RegGravLimit: grav_limit_q <= cfg_i.wdata[GravW-1:0];
        RegKeep:      keep_q       <= cfg_i.wdata;
        RegHeaterThr: heater_thr_q <= cfg_i.wdata;
        default: ;  // unmapped index, drop the write
      endcase
    end
  end

  always_comb begin
    cond_cfg.gyro_off_x = gyro_off_x_q;
    cond_cfg.gyro_off_y = gyro_off_y_q;
    cond_cfg.gyro_off_z = gyro_off_z_q;
    cond_cfg.grav_limit = grav_limit_q;
  end

  assign fire = a_valid && room;

  isc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .frame_i    (frame_i.data),
    .cfg_i      (cond_cfg),
    .adv_i      (room),
    .valid_o    (a_valid),
    .cond_o     (cond)
  );

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    isc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .fire_i  (fire),
      .first_i (first_q),
      .keep_i  (keep_q),
      .x_i     (cond.ax[i]),
      .y_o     (y[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (fire) begin
      first_q <= 1'b0;
    end
  end

  isc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fire),
    .room_o  (room),
    .y_i     (y),
    .temp_i  (cond.temp_q8),
    .thr_i   (heater_thr_q),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (result_o.data)
  );

  // a frame into the filter always clears the first-frame flag
  a_first_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> !first_q)
    else $error("first-frame flag still set after a filtered frame");

  // a filtered frame must be visible on the output the next cycle
  a_result_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> result_o.valid)
    else $error("filtered frame missing from output");

  // an accepted frame occupies the input stage the next cycle
  a_front_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_i.valid && frame_i.ready) |=> a_valid)
    else $error("accepted frame lost in input stage");

endmodule
